/* src/rtty_sentence_tx_with_crc_macros.svh */
// Assertion macros for the sentence transmitter.
// RTTY_ASSERT is sampled on clk and gated off during reset.
// RTTY_ASSERT_ALWAYS is sampled on clk and also checked while rst_n is low.
`ifndef RTTY_SENTENCE_TX_WITH_CRC_MACROS_SVH
`define RTTY_SENTENCE_TX_WITH_CRC_MACROS_SVH
`ifndef ASSERT_OFF
`define RTTY_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RTTY_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RTTY_ASSERT(lbl, prop, msg)
`define RTTY_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* src/rtty_pkg.sv */
`timescale 1ns / 1ps

package rtty_pkg;

    typedef enum logic
    {
        ST_IDLE,
        ST_SEND
    } state_t;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // character slots of one sentence item: data char, '*', four hex digits
    localparam logic [2:0] CHAR_DATA     = 3'd0;
    localparam logic [2:0] CHAR_STAR     = 3'd1;
    localparam logic [2:0] CHAR_HEX_HI   = 3'd2;
    localparam logic [2:0] CHAR_HEX_MH   = 3'd3;
    localparam logic [2:0] CHAR_HEX_ML   = 3'd4;
    localparam logic [2:0] CHAR_HEX_LO   = 3'd5;

    // bit slots of one frame
    localparam logic [3:0] BIT_START     = 4'd0;
    localparam logic [3:0] BIT_DATA_LAST = 4'd7;
    localparam logic [3:0] BIT_STOP_LAST = 4'd9;

    localparam logic [7:0] ASCII_STAR    = 8'h2A;
    localparam logic [1:0] POS_MAX       = 2'd3;
    localparam logic [1:0] SKIP_RESET    = 2'd2;

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] wide;
        begin
            wide = {4'h0, nib};
            if (nib < 4'd10)
            begin
                hex_ascii = 8'h30 + wide;
            end
            else
            begin
                hex_ascii = 8'h37 + wide;
            end
        end
    endfunction

endpackage

/* src/rtty_sentence_tx_with_crc.sv */
`timescale 1ns / 1ps
// Channel   | Signals                                   | Word
// ----------+-------------------------------------------+------------------------------
// input     | s_axis_tvalid/tready/tdata/tlast          | one sentence character
// output    | m_axis_tvalid/tready/tdata/tlast          | one line level (bit time)
// config    | cfg_we, cfg_wdata                         | skip_count
//
// Per item, 10 line bits (60 when tlast is set, with the trailer) leave one
// per cycle through the output register unless the output stalls, then the
// sequencer returns to idle, where it takes the next word. The CRC is a single
// bit-serial shift/xor unit stepped 8 times per counted character, in parallel
// with framing that character; the trailer starts only after those 10 bits.
// s_axis_tready is low while a character or its trailer is being framed.
// Reset clears the sequencer, CRC (0xFFFF), position count and skip_count (2).
// Output stalls hold the current bit; the sequencer waits on the output register.
`include "rtty_sentence_tx_with_crc_macros.svh"

module rtty_sentence_tx_with_crc
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       s_axis_tlast,   // last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] line_level, [7:1] zero
    output logic       m_axis_tlast,   // run_end
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata        // skip_count
);
    import rtty_pkg::*;

    state_t      state_reg, state_next;
    logic [1:0]  skip_reg;
    logic [1:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic        crc_busy_reg, crc_busy_next;
    logic [2:0]  crc_bit_reg, crc_bit_next;   // which ch bit feeds the CRC next
    logic [3:0]  bit_idx_reg, bit_idx_next;
    logic [2:0]  char_idx_reg, char_idx_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_level_reg, out_level_next;
    logic        out_last_reg, out_last_next;
    logic [7:0]  ch_reg;
    logic        last_reg;

    logic        accept;
    logic        load;
    logic [7:0]  cur_char;
    logic        cur_level;
    logic        char_done;
    logic        item_done;
    logic        fb;
    logic [2:0]  data_sel;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_level_reg};
    assign m_axis_tlast  = out_last_reg;

    // character now being framed
    always_comb
    begin
        case (char_idx_reg)
            CHAR_DATA:   cur_char = ch_reg;
            CHAR_STAR:   cur_char = ASCII_STAR;
            CHAR_HEX_HI: cur_char = hex_ascii(crc_reg[15:12]);
            CHAR_HEX_MH: cur_char = hex_ascii(crc_reg[11:8]);
            CHAR_HEX_ML: cur_char = hex_ascii(crc_reg[7:4]);
            CHAR_HEX_LO: cur_char = hex_ascii(crc_reg[3:0]);
            default:     cur_char = ASCII_STAR;
        endcase
    end

    // start bit low, 7 data bits LSB first, stop bits high
    assign data_sel = bit_idx_reg[2:0] - 3'd1;
    always_comb
    begin
        if (bit_idx_reg == BIT_START)
        begin
            cur_level = 1'b0;
        end
        else if (bit_idx_reg <= BIT_DATA_LAST)
        begin
            cur_level = cur_char[data_sel];
        end
        else
        begin
            cur_level = 1'b1;
        end
    end

    assign char_done = (bit_idx_reg == BIT_STOP_LAST);
    assign item_done = char_done &&
                       ((char_idx_reg == CHAR_HEX_LO) ||
                        ((char_idx_reg == CHAR_DATA) && !last_reg));
    assign load      = (state_reg == ST_SEND) && (!out_valid_reg || m_axis_tready);

    // shared CRC unit: one polynomial step per cycle, MSB of ch first
    assign fb = crc_reg[15] ^ ch_reg[crc_bit_reg];

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        crc_busy_next  = crc_busy_reg;
        crc_bit_next   = crc_bit_reg;
        bit_idx_next   = bit_idx_reg;
        char_idx_next  = char_idx_reg;
        out_valid_next = out_valid_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;

        if (crc_busy_reg)
        begin
            crc_next = {crc_reg[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            crc_bit_next = crc_bit_reg - 3'd1;
            if (crc_bit_reg == 3'd0)
            begin
                crc_busy_next = 1'b0;
            end
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_SEND;
                    bit_idx_next  = BIT_START;
                    char_idx_next = CHAR_DATA;
                    // only characters past the skipped prefix enter the CRC
                    crc_busy_next = (pos_reg >= skip_reg);
                    crc_bit_next  = 3'd7;
                    if (pos_reg != POS_MAX)
                    begin
                        pos_next = pos_reg + 2'd1;
                    end
                end
            end
            ST_SEND:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = cur_level;
                    out_last_next  = item_done;
                    if (item_done)
                    begin
                        state_next = ST_IDLE;
                        if (last_reg)
                        begin
                            // trailer sent: new sentence starts fresh
                            crc_next = CRC_INIT;
                            pos_next = 2'd0;
                        end
                    end
                    else if (char_done)
                    begin
                        bit_idx_next  = BIT_START;
                        char_idx_next = char_idx_reg + 3'd1;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            skip_reg      <= SKIP_RESET;
            pos_reg       <= 2'd0;
            crc_reg       <= CRC_INIT;
            crc_busy_reg  <= 1'b0;
            crc_bit_reg   <= 3'd7;
            bit_idx_reg   <= BIT_START;
            char_idx_reg  <= CHAR_DATA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            crc_busy_reg  <= crc_busy_next;
            crc_bit_reg   <= crc_bit_next;
            bit_idx_reg   <= bit_idx_next;
            char_idx_reg  <= char_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                skip_reg <= cfg_wdata;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        out_level_reg <= out_level_next;
        out_last_reg  <= out_last_next;
        if (accept)
        begin
            ch_reg   <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    `RTTY_ASSERT_ALWAYS(a_crc_only_in_send,
        !crc_busy_reg || (state_reg == ST_SEND),
        "CRC unit running outside a character")
    `RTTY_ASSERT(a_accept_starts_send,
        accept |=> (state_reg == ST_SEND),
        "accepted character did not start framing")
    `RTTY_ASSERT(a_run_end_is_stop_bit,
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[0],
        "run end not on a stop bit")
    `RTTY_ASSERT(a_crc_done_before_trailer,
        (state_reg == ST_SEND && char_idx_reg != CHAR_DATA) |-> !crc_busy_reg,
        "trailer started before CRC finished")
    `RTTY_ASSERT(a_crc_cleared_after_sentence,
        (load && item_done && last_reg) |=> (crc_reg == CRC_INIT && pos_reg == 2'd0),
        "CRC not reset after trailer")

endmodule

/* verif/rtty_sentence_tx_with_crc_test.sv */
`timescale 1ns / 1ps

module rtty_sentence_tx_with_crc_test;

    import rtty_pkg::CRC_INIT;
    import rtty_pkg::CRC_POLY;
    import rtty_pkg::ASCII_STAR;
    import rtty_pkg::POS_MAX;
    import rtty_pkg::SKIP_RESET;

    // Run limits. Worst case is ~250 words each with a trailer (60 bits),
    // a 21% output stall, sender gaps and one long hold-off; the limit
    // below is several times that.
    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned SETTLE_CYCLES = 16;   // > one 10-bit frame of slack
    localparam int unsigned HOLD_CYCLES   = 400;  // long output hold-off
    localparam int unsigned HOLD_AT_WORD  = 140;  // starts once this many words are in
    localparam int unsigned IDLE_PCT      = 21;
    localparam int unsigned PRINT_CAP     = 40;   // mismatch lines printed at most

    // ASCII glyphs for trailer digits, '0' in the top byte
    localparam logic [127:0] HEX_GLYPHS = "0123456789ABCDEF";

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] ch
    logic       s_axis_tlast;    // last
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [0] line_level, [7:1] zero
    logic       m_axis_tlast;    // run_end
    logic       cfg_we;
    logic [1:0] cfg_wdata;       // skip_count

    rtty_sentence_tx_with_crc uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // One expected line bit: level on the wire plus the end-of-word marker.
    typedef struct
    {
        logic level;
        logic run_end;
    } line_bit_t;

    // One row of the directed table. A config row only writes skip_count.
    // crc_typed rows carry a trailer value read straight off the spec
    // (whole sentence skipped -> "*FFFF"); the rest go through the predictor.
    typedef struct
    {
        bit         is_cfg;
        logic [1:0] skip_val;
        logic [7:0] ch;
        logic       is_last;
        bit         crc_typed;
        logic [15:0] crc_want;
    } stim_row_t;

    line_bit_t   line_bits_due[$];
    stim_row_t   directed_rows[$];

    // predictor state: shadow of the CRC, sentence position and register
    logic [15:0] crc_shadow;
    logic [1:0]  pos_shadow;
    logic [1:0]  skip_shadow;

    int unsigned mismatch_count;
    int unsigned items_accepted;
    int unsigned cycle_count;
    int unsigned hold_left;
    bit          hold_done;
    bit          steady_flow;     // no random idling on either side while set (the hold-off still applies)

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Global cycle limit; a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // CRC-16, poly 0x1021, MSB first, one byte per call
    function automatic logic [15:0] crc_step_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        int          i;
        r = acc;
        for (i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
        int idx;
        idx = 15 - int'(nib);
        return HEX_GLYPHS[idx * 8 +: 8];
    endfunction

    // Queue the ten line bits of one 7N2 frame: start 0, 7 data LSB first,
    // two stop 1s. run_end marks the second stop bit if this frame closes the word.
    function automatic void queue_frame(input logic [7:0] c, input logic closes_word);
        line_bit_t b;
        int        k;
        b.run_end = 1'b0;
        b.level   = 1'b0;
        line_bits_due.push_back(b);
        for (k = 0; k < 7; k++)
        begin
            b.level = c[k];
            line_bits_due.push_back(b);
        end
        b.level = 1'b1;
        line_bits_due.push_back(b);
        b.run_end = closes_word;
        line_bits_due.push_back(b);
    endfunction

    // Expected line bits for one accepted sentence word.
    function automatic void predict_sentence_char(input logic [7:0] c, input logic is_last,
                                                  input bit crc_typed, input logic [15:0] crc_want);
        logic [15:0] trailer_crc;
        if (pos_shadow >= skip_shadow)
        begin
            crc_shadow = crc_step_byte(crc_shadow, c);
        end
        if (pos_shadow != POS_MAX)
        begin
            pos_shadow = pos_shadow + 2'd1;
        end
        queue_frame(c, !is_last);
        if (is_last)
        begin
            trailer_crc = crc_typed ? crc_want : crc_shadow;
            queue_frame(ASCII_STAR, 1'b0);
            queue_frame(hex_glyph(trailer_crc[15:12]), 1'b0);
            queue_frame(hex_glyph(trailer_crc[11:8]), 1'b0);
            queue_frame(hex_glyph(trailer_crc[7:4]), 1'b0);
            queue_frame(hex_glyph(trailer_crc[3:0]), 1'b1);
            crc_shadow = CRC_INIT;
            pos_shadow = 2'd0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall generator and checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        begin
            if (mismatch_count < PRINT_CAP)
            begin
                $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
            end
            mismatch_count++;
        end
    endtask

    // Random tready with one long hold-off once enough words have gone in;
    // during the hold-off the sender keeps offering, so the block backs up.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        hold_done     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_accepted >= HOLD_AT_WORD)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Compare each accepted line bit with the oldest expectation.
    always @(posedge clk)
    begin : line_check
        line_bit_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (line_bits_due.size() == 0)
            begin
                report_mismatch("unexpected line bit", m_axis_tdata, 8'h00);
            end
            else
            begin
                want = line_bits_due.pop_front();
                if (m_axis_tdata[0] !== want.level)
                begin
                    report_mismatch("line_level", {7'd0, m_axis_tdata[0]}, {7'd0, want.level});
                end
                if (m_axis_tdata[7:1] !== 7'd0)
                begin
                    report_mismatch("tdata pad", {1'b0, m_axis_tdata[7:1]}, 8'h00);
                end
                if (m_axis_tlast !== want.run_end)
                begin
                    report_mismatch("run_end", {7'd0, m_axis_tlast}, {7'd0, want.run_end});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one sentence word, with random gaps ahead of it. tvalid stays
    // high from one word to the next when no gap is drawn.
    task automatic push_char(input logic [7:0] c, input logic is_last,
                             input bit crc_typed, input logic [15:0] crc_want);
        begin
            while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= c;
            s_axis_tlast  <= is_last;
            @(posedge clk);
            while (!s_axis_tready)
            begin
                @(posedge clk);
            end
            predict_sentence_char(c, is_last, crc_typed, crc_want);
            items_accepted++;
        end
    endtask

    // Register write only with the block idle: stop offering, let every
    // expected bit drain, give the sequencer a frame of slack, then write.
    task automatic write_skip(input logic [1:0] v);
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (line_bits_due.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= v;
            @(posedge clk);
            skip_shadow = v;
            cfg_we <= 1'b0;
        end
    endtask

    function automatic void add_row(input bit is_cfg, input logic [1:0] skip_val,
                                    input logic [7:0] ch, input logic is_last,
                                    input bit crc_typed, input logic [15:0] crc_want);
        stim_row_t r;
        r.is_cfg    = is_cfg;
        r.skip_val  = skip_val;
        r.ch        = ch;
        r.is_last   = is_last;
        r.crc_typed = crc_typed;
        r.crc_want  = crc_want;
        directed_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int          ph;
        int          n;
        int          sent_len;
        int          k;
        logic [1:0]  phase_skip;
        stim_row_t   r;

        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        s_axis_tlast   = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 2'd0;
        crc_shadow     = CRC_INIT;
        pos_shadow     = 2'd0;
        skip_shadow    = SKIP_RESET;
        items_accepted = 0;
        steady_flow    = 1'b0;

        // Directed table.
        // skip_count at its reset value 2: one- and two-word sentences are
        // wholly skipped, so the trailer must read *FFFF.
        add_row(1'b0, 2'd0, 8'h00, 1'b1, 1'b1, 16'hFFFF);
        add_row(1'b0, 2'd0, 8'h7F, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'hFF, 1'b1, 1'b1, 16'hFFFF);
        // longer sentence: position count saturates, the first two words stay out of the CRC
        add_row(1'b0, 2'd0, 8'h80, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'h55, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'hAA, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'h01, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'hFE, 1'b1, 1'b0, 16'h0000);
        // skip_count 0: every word counts
        add_row(1'b1, 2'd0, 8'h00, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'h00, 1'b1, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'hFF, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, ASCII_STAR, 1'b1, 1'b0, 16'h0000);
        // skip_count 3: a three-word sentence is wholly skipped
        add_row(1'b1, 2'd3, 8'h00, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'h10, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'h20, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'h30, 1'b1, 1'b1, 16'hFFFF);
        add_row(1'b0, 2'd0, 8'h47, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'h50, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'h47, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'h47, 1'b0, 1'b0, 16'h0000);
        add_row(1'b0, 2'd0, 8'h41, 1'b1, 1'b0, 16'h0000);

        @(posedge rst_n);
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.is_cfg)
            begin
                write_skip(r.skip_val);
            end
            else
            begin
                push_char(r.ch, r.is_last, r.crc_typed, r.crc_want);
            end
        end

        // Random part: five phases of ~50 words each, sentences of 1..8
        // words with random content. A phase may end mid-sentence, so the
        // register also changes with a sentence half sent.
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: phase_skip = 2'd0;
                1: phase_skip = 2'd3;
                2: phase_skip = 2'd1;
                3: phase_skip = 2'd2;
                default: phase_skip = 2'($urandom_range(0, 3));
            endcase
            write_skip(phase_skip);
            // phase 2 runs with no random idling on either side
            steady_flow = (ph == 2);
            n = 0;
            while (n < 50)
            begin
                sent_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
                for (k = 0; k < sent_len && n < 50; k++)
                begin
                    push_char(8'($urandom_range(0, 255)), k == sent_len - 1, 1'b0, 16'h0000);
                    n++;
                end
            end
            steady_flow = 1'b0;
        end

        // Drain, then allow a frame of slack for anything stray.
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (line_bits_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/rtty_pkg.sv
src/rtty_sentence_tx_with_crc.sv
verif/rtty_sentence_tx_with_crc_test.sv
